@@ rtl/lfr_pkg.sv @@
// Shared constants for the longest free run core.
// No dependencies; imported by the core, the checker and the testbench files.
package lfr_pkg;

  localparam int POSITIONS  = 1024;
  localparam int ADDR_W     = $clog2(POSITIONS);
  localparam int POS_W      = 10;
  localparam int RUN_W      = 11;
  localparam int TOP_W      = (ADDR_W > POS_W) ? ADDR_W : POS_W;
  localparam int CUR_W      = $clog2(POSITIONS + 1);
  localparam int PDATA_W    = 32;
  localparam int PADDR_W    = 3;
  localparam int TOP_RESET  = 1023;

  localparam logic REG_TOP  = 1'b0;

endpackage

@@ rtl/longest_free_run_after_removal_core.sv @@
// Top level of the longest free run core: presence map in RAM, sequential scan.
// Depends on lfr_pkg and lfr_ram.
//
//  channel   dir  handshake             payload
//  input     in   in_valid / in_ready   remove_position
//  output    out  out_valid / out_ready longest_run, ignored
//  config    in   APB psel/penable      paddr, pwdata, prdata
//
// Each word takes one read of the map at the removed position, a write back,
// then a scan of the map RAM, one position per cycle.
// After reset a clearing pass over the map RAM sets every map bit; no
// word is taken meanwhile. A finished result waits in the output register
// while the next word is already being worked on.
module longest_free_run_after_removal_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lfr_pkg::POS_W-1:0]   remove_position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lfr_pkg::RUN_W-1:0]   longest_run,
  output logic                        ignored,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfr_pkg::PADDR_W-1:0] paddr,
  input  logic [lfr_pkg::PDATA_W-1:0] pwdata,
  output logic [lfr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  import lfr_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t             state;
  logic [POS_W-1:0]   top_position;
  logic [TOP_W-1:0]   eff_top;
  logic [ADDR_W-1:0]  clr;
  logic [ADDR_W-1:0]  p;
  logic [POS_W-1:0]   pos;
  logic               out_of_range;
  logic               skip;
  logic               issue_done;
  logic               pend;
  logic               pend_last;
  logic [CUR_W-1:0]   cur;
  logic [CUR_W-1:0]   best;
  logic [CUR_W-1:0]   cur_next;
  logic [CUR_W-1:0]   best_next;
  logic               skip_next;
  logic               in_acc;
  logic               out_load;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [0:0]         ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [0:0]         ram_rdata;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_position <= POS_W'(TOP_RESET);
    end else if (psel && penable && pwrite && (paddr[2] == REG_TOP)) begin
      top_position <= pwdata[POS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TOP) begin
      prdata = PDATA_W'(top_position);
    end
  end

  always_comb begin
    if (TOP_W'(top_position) >= TOP_W'(POSITIONS - 1)) begin
      eff_top = TOP_W'(POSITIONS - 1);
    end else begin
      eff_top = TOP_W'(top_position);
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  assign skip_next = out_of_range || !ram_rdata[0];
  assign cur_next  = ram_rdata[0] ? (cur + CUR_W'(1)) : '0;
  assign best_next = (cur_next > best) ? cur_next : best;

  // Map RAM port usage
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr;
    ram_wdata = 1'b1;
    ram_re    = 1'b0;
    ram_raddr = p;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_re    = in_acc;
        ram_raddr = ADDR_W'(remove_position);
      end
      ST_CHECK: begin
        ram_we    = !skip_next;
        ram_waddr = ADDR_W'(pos);
        ram_wdata = 1'b0;
      end
      ST_SCAN: begin
        ram_re = !issue_done;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lfr_ram #(
    .WIDTH (1),
    .DEPTH (POSITIONS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr        <= '0;
      issue_done <= 1'b0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (clr == ADDR_W'(POSITIONS - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr <= clr + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state      <= ST_SCAN;
          issue_done <= 1'b0;
          pend       <= 1'b0;
        end
        ST_SCAN: begin
          pend <= !issue_done;
          if (!issue_done && (TOP_W'(p) == eff_top)) begin
            issue_done <= 1'b1;
          end
          if (pend && pend_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
          clr   <= '0;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos          <= remove_position;
      out_of_range <= TOP_W'(remove_position) > eff_top;
    end
    if (state == ST_CHECK) begin
      skip <= skip_next;
      p    <= '0;
      cur  <= '0;
      best <= '0;
    end
    if (state == ST_SCAN) begin
      if (!issue_done) begin
        pend_last <= (TOP_W'(p) == eff_top);
        if (TOP_W'(p) != eff_top) begin
          p <= p + ADDR_W'(1);
        end
      end
      if (pend) begin
        cur  <= cur_next;
        best <= best_next;
      end
    end
    if (out_load) begin
      longest_run <= RUN_W'(best);
      ignored     <= skip;
    end
  end

endmodule

@@ rtl/lfr_ram.sv @@
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module lfr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/lfr_checker.sv @@
// Port-level checks for the longest free run core, attached by bind.
// Depends on lfr_pkg and longest_free_run_after_removal_core.
module lfr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [lfr_pkg::RUN_W-1:0] longest_run,
  input logic                      ignored,
  input logic                      pready
);

  import lfr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(longest_run) && $stable(ignored))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while a word is in work");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result shown before the scan could run");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid && pready)
    else $error("input open during the map clearing pass");

endmodule

bind longest_free_run_after_removal_core lfr_checker u_lfr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .longest_run (longest_run),
  .ignored     (ignored),
  .pready      (pready)
);

@@ tb/longest_run_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the longest free run core: predicts each result word from its own presence map.
// Watches the input, output and register channels; depends on lfr_pkg.
module longest_run_checker
  import lfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [POS_W-1:0]   remove_position,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [RUN_W-1:0]   longest_run,
  input  logic               ignored,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 pending_words
);

  localparam logic [PADDR_W-1:0] TOP_ADDR = PADDR_W'(4 * REG_TOP);

  typedef struct packed {
    logic [RUN_W-1:0] run;
    logic             skipped;
  } removal_result_t;

  bit               present [POSITIONS];
  logic [TOP_W-1:0] top_reg;
  removal_result_t  expected_runs [$];

  function automatic removal_result_t predict_removal(input logic [POS_W-1:0] pos);
    removal_result_t res;
    int unsigned     span;
    int unsigned     best;
    int unsigned     cur;
    span = (top_reg >= POSITIONS) ? POSITIONS - 1 : top_reg;
    res.skipped = (pos > span) || !present[pos];
    if (!res.skipped)
      present[pos] = 1'b0;
    best = 0;
    cur = 0;
    for (int p = 0; p <= span; p++) begin
      if (present[p]) begin
        cur++;
        if (cur > best)
          best = cur;
      end else begin
        cur = 0;
      end
    end
    res.run = RUN_W'(best);
    return res;
  endfunction

  always @(posedge clk) begin
    removal_result_t want;
    if (rst) begin
      foreach (present[i])
        present[i] = 1'b1;
      top_reg = TOP_W'(TOP_RESET);
      expected_runs.delete();
      mismatches = 0;
      pending_words <= 0;
    end else begin
      if (psel && penable && pready && paddr == TOP_ADDR) begin
        if (pwrite) begin
          top_reg = pwdata[TOP_W-1:0];
        end else if (prdata !== PDATA_W'(top_reg)) begin
          $display("%0t: top_position read expected %0d, got %0d", $time, top_reg, prdata);
          mismatches++;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          $display("%0t: result word expected none, got run %0d ignored %0b",
                   $time, longest_run, ignored);
          mismatches++;
        end else begin
          want = expected_runs.pop_front();
          if (longest_run !== want.run) begin
            $display("%0t: longest_run expected %0d, got %0d", $time, want.run, longest_run);
            mismatches++;
          end
          if (ignored !== want.skipped) begin
            $display("%0t: ignored expected %0b, got %0b", $time, want.skipped, ignored);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_runs.push_back(predict_removal(remove_position));
      pending_words <= expected_runs.size();
    end
  end

endmodule

@@ tb/longest_free_run_after_removal_core_test.sv @@
`timescale 1ns / 100ps
// Stimulus and verdict for longest_free_run_after_removal_core: removals, top changes, stalls.
// Depends on lfr_pkg, the core and longest_run_checker.
module longest_free_run_after_removal_core_test;
  import lfr_pkg::*;

  localparam int WATCHDOG_LIMIT  = 10000;
  localparam int DRAIN_CYCLES    = POSITIONS + 64;
  localparam int TARGET_REMOVALS = 580;
  localparam logic [PADDR_W-1:0] TOP_ADDR = PADDR_W'(4 * REG_TOP);

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [POS_W-1:0]   remove_position = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [RUN_W-1:0]   longest_run;
  logic               ignored;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int          mismatches;
  int          pending_words;
  int          idle_count = 0;
  int          applied = 0;
  int          sent = 0;
  int unsigned top_now = TOP_RESET;
  bit          steady = 1'b0;
  bit          gone [POSITIONS];

  longest_free_run_after_removal_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .remove_position(remove_position),
    .out_valid(out_valid), .out_ready(out_ready),
    .longest_run(longest_run), .ignored(ignored),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  longest_run_checker check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .remove_position(remove_position),
    .out_valid(out_valid), .out_ready(out_ready),
    .longest_run(longest_run), .ignored(ignored),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatches(mismatches), .pending_words(pending_words)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 29);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
      idle_count <= 0;
    end else if (idle_count == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic send_removal(input logic [POS_W-1:0] pos);
    if (!steady) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    remove_position <= pos;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (pos <= top_now && !gone[pos]) begin
      gone[pos] = 1'b1;
      applied++;
    end
  endtask

  task automatic set_top(input int unsigned value);
    logic [PDATA_W-1:0] word;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    word = $urandom;
    word[TOP_W-1:0] = value[TOP_W-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TOP_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    top_now = 32'(value[TOP_W-1:0]);
  endtask

  initial begin
    int               phase;
    int               count;
    int               kind;
    int unsigned      start;
    int unsigned      p;
    int unsigned      window;
    logic [POS_W-1:0] pos;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_removal('0);
    send_removal(POS_W'(POSITIONS - 1));
    send_removal(512);
    send_removal(512);
    send_removal(511);
    send_removal(513);
    set_top(0);
    send_removal(0);
    send_removal(POS_W'(POSITIONS - 1));
    send_removal(1);
    set_top(1);
    send_removal(1);
    send_removal(2);
    set_top(5);
    send_removal(3);
    send_removal(5);
    send_removal(4);
    send_removal(4);
    set_top(POSITIONS - 1);
    send_removal(700);
    send_removal(1022);

    phase = 0;
    while (sent < TARGET_REMOVALS) begin
      kind = $urandom_range(9);
      steady = (phase >= 10 && phase < 18);
      if (kind == 0) begin
        set_top(POSITIONS - 1);
        count = 3;
      end else if (kind == 1) begin
        set_top($urandom_range(15, 0));
        count = 6;
      end else begin
        window = applied + 8 + $urandom_range(56, 0);
        set_top((window > POSITIONS - 1) ? POSITIONS - 1 : window);
        count = $urandom_range(24, 8);
      end
      repeat (count) begin
        pos = POS_W'($urandom_range(POSITIONS - 1, 0));
        if ($urandom_range(99) < 80) begin
          start = $urandom_range(top_now, 0);
          for (int i = 0; i <= top_now; i++) begin
            p = (start + i) % (top_now + 1);
            if (!gone[p]) begin
              pos = p[POS_W-1:0];
              break;
            end
          end
        end else if ($urandom_range(1)) begin
          pos = POS_W'($urandom_range(top_now, 0));
        end
        send_removal(pos);
      end
      phase++;
    end

    steady = 1'b0;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/lfr_pkg.sv
rtl/lfr_ram.sv
rtl/longest_free_run_after_removal_core.sv
rtl/lfr_checker.sv
tb/longest_run_checker.sv
tb/longest_free_run_after_removal_core_test.sv
